/* hdl/ratt_pkg.sv */
// shared constants and status codes for the region address translation table
package ratt_pkg;
    localparam int ENTRIES   = 16;
    localparam int ADDR_BITS = 64;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 3);
    localparam int ROW_W     = 3 * ADDR_BITS;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_MISS   = 3'd1;
    localparam logic [2:0] ST_BOUNDS = 3'd2;
    localparam logic [2:0] ST_SIZE   = 3'd3;
    localparam logic [2:0] ST_POVL   = 3'd4;
    localparam logic [2:0] ST_SOVL   = 3'd5;
    localparam logic [2:0] ST_NOORIG = 3'd6;
    localparam logic [2:0] ST_FULL   = 3'd7;

    typedef logic [ADDR_BITS-1:0] t_addr;
endpackage

/* hdl/ratt_ram.sv */
// generic single write port ram with registered read
module ratt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/region_address_translation_table.sv */
// region address translation table: lookup, add and update over a scanned region ram
//
// channel   direction  handshake                      payload
// command   in         i_start && !o_busy             i_cmd, i_addr, range bounds
// result    out        o_valid, one cycle, no stall   o_status, o_translated_addr
// config    in         i_cfg_valid && o_cfg_ready     i_cfg_data (translation_off)
//
// a request that needs the table runs the one-row-a-cycle scan of the region ram
// through a two stage compare pipe; early outcomes skip the scan. valid bits clear
// at reset, no clearing pass. o_busy is high from accept until the result
// register is loaded; the result receiver cannot stall.
module region_address_translation_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_addr,
    input  logic [63:0] i_proc_start,
    input  logic [63:0] i_proc_end,
    input  logic [63:0] i_sim_start,
    input  logic [63:0] i_sim_end,
    input  logic [63:0] i_orig_start,
    input  logic [63:0] i_orig_end,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [63:0] o_translated_addr,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    localparam int E = ratt_pkg::ENTRIES;
    localparam int A = ratt_pkg::ADDR_BITS;
    localparam int IW = ratt_pkg::IDX_W;
    localparam int CW = ratt_pkg::CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_off;
    logic [E-1:0] r_valid;

    // latched request
    logic [1:0]     r_cmd;
    ratt_pkg::t_addr r_addr, r_ps, r_pe, r_ss, r_se, r_os, r_oe;

    logic [CW-1:0]  r_cnt;
    logic           r_early;
    logic [2:0]     r_early_st;

    // stage one (ram data present)
    logic           r_rd_v;
    logic [IW-1:0]  r_rd_idx;
    // stage two
    logic           r_s2_v, r_s2_vld;
    logic [IW-1:0]  r_s2_idx;
    ratt_pkg::t_addr r_s2_sb, r_s2_len;

    logic [E-1:0]   r_povl, r_sovl;
    logic           r_hit, r_found;
    logic [IW-1:0]  r_slot;
    ratt_pkg::t_addr r_hit_off, r_hit_sim;

    logic [ratt_pkg::ROW_W-1:0] ram_rdata, ram_wdata;
    logic           ram_we;
    logic [IW-1:0]  ram_waddr, ram_raddr;

    ratt_pkg::t_addr rd_pb, rd_pl, rd_sb, s2_sl, lk_sum;
    logic            rd_vld, accept, issue;

    logic [E-1:0]    skip_mask;
    logic            free_any;
    logic [IW-1:0]   free_idx;
    logic [2:0]      fin_st;
    logic            fin_wr;
    logic [IW-1:0]   fin_slot;
    ratt_pkg::t_addr fin_res;

    assign accept      = i_start && !o_busy;
    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign issue     = (r_state == S_SCAN) && (r_cnt < CW'(E));
    assign ram_raddr = r_cnt[IW-1:0];

    assign rd_pb  = ram_rdata[3*A-1:2*A];
    assign rd_pl  = ram_rdata[2*A-1:A];
    assign rd_sb  = ram_rdata[A-1:0];
    assign rd_vld = r_valid[r_rd_idx];
    assign s2_sl  = r_s2_sb + r_s2_len;
    assign lk_sum = r_hit_sim + r_hit_off;

    ratt_ram #(
        .WIDTH(ratt_pkg::ROW_W),
        .DEPTH(E)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // lowest free slot and the original slot mask
    always_comb begin
        free_any  = 1'b0;
        free_idx  = '0;
        skip_mask = '0;
        for (int i = E - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
        skip_mask[r_slot] = r_found;
    end

    always_comb begin
        fin_st   = ratt_pkg::ST_MISS;
        fin_wr   = 1'b0;
        fin_slot = r_slot;
        fin_res  = '0;
        if (r_early) begin
            fin_st = r_early_st;
            if (r_cmd == ratt_pkg::CMD_LOOKUP && r_early_st == ratt_pkg::ST_OK) begin
                fin_res = r_addr;
            end
        end else begin
            unique case (r_cmd)
                ratt_pkg::CMD_LOOKUP: begin
                    fin_st  = r_hit ? ratt_pkg::ST_OK : ratt_pkg::ST_MISS;
                    fin_res = r_hit ? lk_sum : '0;
                end
                ratt_pkg::CMD_ADD: begin
                    fin_slot = free_idx;
                    priority if (|r_povl) fin_st = ratt_pkg::ST_POVL;
                    else if (|r_sovl)     fin_st = ratt_pkg::ST_SOVL;
                    else if (!free_any)   fin_st = ratt_pkg::ST_FULL;
                    else begin
                        fin_st = ratt_pkg::ST_OK;
                        fin_wr = 1'b1;
                    end
                end
                ratt_pkg::CMD_UPDATE: begin
                    priority if (!r_found)         fin_st = ratt_pkg::ST_NOORIG;
                    else if (|(r_povl & ~skip_mask)) fin_st = ratt_pkg::ST_POVL;
                    else if (|(r_sovl & ~skip_mask)) fin_st = ratt_pkg::ST_SOVL;
                    else begin
                        fin_st = ratt_pkg::ST_OK;
                        fin_wr = 1'b1;
                    end
                end
                default: fin_st = ratt_pkg::ST_MISS;
            endcase
        end
    end

    assign ram_we    = (r_state == S_FIN) && fin_wr;
    assign ram_waddr = fin_slot;
    assign ram_wdata = {r_ps, r_pe, r_ss};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_CHK;
            S_CHK: begin
                if (r_cmd == ratt_pkg::CMD_UNUSED || r_off ||
                    (r_cmd != ratt_pkg::CMD_LOOKUP &&
                    (r_ps >= r_pe || r_ss >= r_se || (r_pe - r_ps) != (r_se - r_ss)))) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: if (r_cnt == CW'(E + 1)) n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_off   <= 1'b0;
            r_valid <= '0;
            r_rd_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            o_valid <= 1'b0;
            r_cnt   <= '0;
            r_early <= 1'b0;
            r_hit   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_FIN);
            r_rd_v  <= issue;
            r_s2_v  <= r_rd_v;
            if (i_cfg_valid && o_cfg_ready) begin
                r_off <= i_cfg_data;
            end
            if (accept) begin
                r_cnt   <= '0;
                r_early <= 1'b0;
                r_hit   <= 1'b0;
                r_found <= 1'b0;
            end
            if (r_state == S_CHK && n_state == S_FIN) begin
                r_early <= 1'b1;
            end
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_rd_v && rd_vld) begin
                if (!r_hit && r_addr >= rd_pb && r_addr < rd_pl) begin
                    r_hit <= 1'b1;
                end
                if (!r_found && rd_pb == r_os && rd_pl == r_oe) begin
                    r_found <= 1'b1;
                end
            end
            if (ram_we) begin
                r_valid[fin_slot] <= 1'b1;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_addr <= i_addr[A-1:0];
            r_ps   <= i_proc_start[A-1:0];
            r_pe   <= i_proc_end[A-1:0];
            r_ss   <= i_sim_start[A-1:0];
            r_se   <= i_sim_end[A-1:0];
            r_os   <= i_orig_start[A-1:0];
            r_oe   <= i_orig_end[A-1:0];
            r_povl <= '0;
            r_sovl <= '0;
        end
        if (r_state == S_CHK) begin
            priority if (r_cmd == ratt_pkg::CMD_UNUSED)  r_early_st <= ratt_pkg::ST_MISS;
            else if (r_off)                              r_early_st <= ratt_pkg::ST_OK;
            else if (r_ps >= r_pe || r_ss >= r_se)       r_early_st <= ratt_pkg::ST_BOUNDS;
            else                                         r_early_st <= ratt_pkg::ST_SIZE;
        end
        r_rd_idx <= ram_raddr;
        if (r_rd_v) begin
            r_s2_idx <= r_rd_idx;
            r_s2_vld <= rd_vld;
            r_s2_sb  <= rd_sb;
            r_s2_len <= rd_pl - rd_pb;
            r_povl[r_rd_idx] <= rd_vld && r_ps < rd_pl && rd_pb < r_pe;
            if (rd_vld && !r_hit && r_addr >= rd_pb && r_addr < rd_pl) begin
                r_hit_off <= r_addr - rd_pb;
                r_hit_sim <= rd_sb;
            end
            if (rd_vld && !r_found && rd_pb == r_os && rd_pl == r_oe) begin
                r_slot <= r_rd_idx;
            end
        end
        if (r_s2_v) begin
            r_sovl[r_s2_idx] <= r_s2_vld && r_ss < s2_sl && r_s2_sb < r_se;
        end
        if (r_state == S_FIN) begin
            o_status          <= fin_st;
            o_translated_addr <= 64'(fin_res);
        end
    end

`ifndef SYNTHESIS
    a_result_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_FIN)
        else $error("result strobe without a finish cycle");
    a_write_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_FIN && !r_early))
        else $error("region ram written outside a table update");
    a_accept_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_CHK)
        else $error("accepted request did not reach the check cycle");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cnt <= CW'(E + 1))
        else $error("scan counter ran past the table");
`endif
endmodule

/* bench/tb_region_address_translation_table.sv */
// self-checking testbench for the region address translation table
module tb_region_address_translation_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] cmd;
        ratt_pkg::t_addr addr, ps, pe, ss, se, os, oe;
        logic       chk;
        logic [2:0] st;
        ratt_pkg::t_addr ta;
    } t_req;

    typedef struct packed {
        logic [2:0] st;
        ratt_pkg::t_addr ta;
    } t_resp;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic        o_busy;
    logic [1:0]  i_cmd = 0;
    logic [63:0] i_addr = 0, i_proc_start = 0, i_proc_end = 0;
    logic [63:0] i_sim_start = 0, i_sim_end = 0, i_orig_start = 0, i_orig_end = 0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [63:0] o_translated_addr;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 0;

    region_address_translation_table dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic  mdl_off;
    logic  mdl_vld [ratt_pkg::ENTRIES];
    ratt_pkg::t_addr mdl_pb [ratt_pkg::ENTRIES];
    ratt_pkg::t_addr mdl_pl [ratt_pkg::ENTRIES];
    ratt_pkg::t_addr mdl_sb [ratt_pkg::ENTRIES];

    t_resp pending_results[$];
    int    fails = 0;
    int    idle_cycles = 0;
    bit    quiet = 0;
    t_req  dir_rows[$];

    function automatic bit ovl(ratt_pkg::t_addr a0, ratt_pkg::t_addr a1,
                               ratt_pkg::t_addr b0, ratt_pkg::t_addr b1);
        return a0 < b1 && b0 < a1;
    endfunction

    function automatic t_resp translate_step(t_req r);
        t_resp res;
        int slot;
        res.st = ratt_pkg::ST_MISS;
        res.ta = '0;
        slot = ratt_pkg::ENTRIES;
        if (r.cmd == ratt_pkg::CMD_LOOKUP) begin
            if (mdl_off) begin
                res.st = ratt_pkg::ST_OK;
                res.ta = r.addr;
            end else begin
                for (int i = 0; i < ratt_pkg::ENTRIES; i++)
                    if (mdl_vld[i] && r.addr >= mdl_pb[i] && r.addr < mdl_pl[i]) begin
                        res.st = ratt_pkg::ST_OK;
                        res.ta = mdl_sb[i] + (r.addr - mdl_pb[i]);
                        break;
                    end
            end
        end else if (r.cmd == ratt_pkg::CMD_ADD || r.cmd == ratt_pkg::CMD_UPDATE) begin
            if (mdl_off) res.st = ratt_pkg::ST_OK;
            else if (r.ps >= r.pe || r.ss >= r.se) res.st = ratt_pkg::ST_BOUNDS;
            else if (r.pe - r.ps != r.se - r.ss) res.st = ratt_pkg::ST_SIZE;
            else begin
                res.st = ratt_pkg::ST_OK;
                if (r.cmd == ratt_pkg::CMD_UPDATE) begin
                    for (int i = 0; i < ratt_pkg::ENTRIES; i++)
                        if (mdl_vld[i] && mdl_pb[i] == r.os && mdl_pl[i] == r.oe) begin
                            slot = i;
                            break;
                        end
                    if (slot >= ratt_pkg::ENTRIES) res.st = ratt_pkg::ST_NOORIG;
                end
                if (res.st == ratt_pkg::ST_OK)
                    for (int i = 0; i < ratt_pkg::ENTRIES; i++)
                        if (mdl_vld[i] && i != slot &&
                            ovl(r.ps, r.pe, mdl_pb[i], mdl_pl[i])) begin
                            res.st = ratt_pkg::ST_POVL;
                            break;
                        end
                if (res.st == ratt_pkg::ST_OK)
                    for (int i = 0; i < ratt_pkg::ENTRIES; i++)
                        if (mdl_vld[i] && i != slot &&
                            ovl(r.ss, r.se, mdl_sb[i], mdl_sb[i] + (mdl_pl[i] - mdl_pb[i]))) begin
                            res.st = ratt_pkg::ST_SOVL;
                            break;
                        end
                if (res.st == ratt_pkg::ST_OK && r.cmd == ratt_pkg::CMD_ADD) begin
                    for (int i = 0; i < ratt_pkg::ENTRIES; i++)
                        if (!mdl_vld[i]) begin
                            slot = i;
                            break;
                        end
                    if (slot >= ratt_pkg::ENTRIES) res.st = ratt_pkg::ST_FULL;
                end
                if (res.st == ratt_pkg::ST_OK && slot < ratt_pkg::ENTRIES) begin
                    mdl_vld[slot] = 1;
                    mdl_pb[slot] = r.ps;
                    mdl_pl[slot] = r.pe;
                    mdl_sb[slot] = r.ss;
                end
            end
        end
        return res;
    endfunction

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        t_resp e;
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result status=%0d addr=%h", o_status, o_translated_addr);
                    fails++;
                end else begin
                    e = pending_results.pop_front();
                    if (o_status !== e.st) begin
                        $error("status expected %0d actual %0d", e.st, o_status);
                        fails++;
                    end
                    if (o_translated_addr !== e.ta) begin
                        $error("translated_addr expected %h actual %h", e.ta,
                               o_translated_addr);
                        fails++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // start stays high between back to back requests and drops during gaps
    task automatic idle_gap();
        if (!quiet)
            while ($urandom_range(99) < 26) begin
                i_start <= 0;
                @(negedge i_clk);
            end
    endtask

    task automatic send(t_req r);
        t_resp res;
        idle_gap();
        i_cmd <= r.cmd;
        i_addr <= r.addr;
        i_proc_start <= r.ps;
        i_proc_end <= r.pe;
        i_sim_start <= r.ss;
        i_sim_end <= r.se;
        i_orig_start <= r.os;
        i_orig_end <= r.oe;
        i_start <= 1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        res = translate_step(r);
        if (r.chk && res.st !== r.st) begin
            $error("table row status expected %0d actual %0d", r.st, res.st);
            fails++;
        end
        if (r.chk && res.ta !== r.ta) begin
            $error("table row translated_addr expected %h actual %h", r.ta, res.ta);
            fails++;
        end
        pending_results = {pending_results, res};
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_start <= 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic set_off(logic v);
        drain();
        i_cfg_data <= v;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mdl_off = v;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    function automatic t_req row(logic [1:0] c, ratt_pkg::t_addr a,
                                 ratt_pkg::t_addr ps, ratt_pkg::t_addr pe,
                                 ratt_pkg::t_addr ss, ratt_pkg::t_addr se,
                                 ratt_pkg::t_addr os, ratt_pkg::t_addr oe,
                                 logic chk, logic [2:0] st, ratt_pkg::t_addr ta);
        t_req r;
        r = '{c, a, ps, pe, ss, se, os, oe, chk, st, ta};
        return r;
    endfunction

    function automatic ratt_pkg::t_addr rnd64();
        return {$urandom, $urandom};
    endfunction

    // most random items live in a small window so ranges collide often
    function automatic t_req rand_req();
        t_req r;
        ratt_pkg::t_addr sz;
        int k;
        k = $urandom_range(99);
        r = '0;
        r.cmd = (k < 40) ? ratt_pkg::CMD_LOOKUP : (k < 70) ? ratt_pkg::CMD_ADD :
                (k < 95) ? ratt_pkg::CMD_UPDATE : ratt_pkg::CMD_UNUSED;
        sz = $urandom_range(1, 64);
        r.ps = $urandom_range(0, 1023);
        r.ss = $urandom_range(0, 1023) + 64'h1000;
        if ($urandom_range(9) == 0) begin
            r.ps = rnd64();
            r.ss = rnd64();
        end
        r.pe = r.ps + sz;
        r.se = r.ss + sz;
        if ($urandom_range(9) == 0) r.se = r.ss + $urandom_range(0, 64);
        if ($urandom_range(19) == 0) r.pe = r.ps - $urandom_range(0, 3);
        r.addr = ($urandom_range(4) == 0) ? rnd64() :
                 ratt_pkg::t_addr'($urandom_range(0, 1100));
        k = $urandom_range(ratt_pkg::ENTRIES - 1);
        if (mdl_vld[k] && $urandom_range(3) != 0) begin
            r.os = mdl_pb[k];
            r.oe = mdl_pl[k];
        end else begin
            r.os = rnd64();
            r.oe = rnd64();
        end
        return r;
    endfunction

    initial begin
        ratt_pkg::t_addr mx;
        mx = '1;
        mdl_off = 0;
        for (int i = 0; i < ratt_pkg::ENTRIES; i++) begin
            mdl_vld[i] = 0;
            mdl_pb[i] = 0;
            mdl_pl[i] = 0;
            mdl_sb[i] = 0;
        end
        dir_rows = '{
            row(ratt_pkg::CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_MISS, 0),
            row(ratt_pkg::CMD_LOOKUP, mx, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_MISS, 0),
            row(ratt_pkg::CMD_ADD, 0, 10, 10, 0, 5, 0, 0, 1, ratt_pkg::ST_BOUNDS, 0),
            row(ratt_pkg::CMD_ADD, 0, 0, 5, 9, 3, 0, 0, 1, ratt_pkg::ST_BOUNDS, 0),
            row(ratt_pkg::CMD_ADD, 0, 0, 5, 0, 6, 0, 0, 1, ratt_pkg::ST_SIZE, 0),
            row(ratt_pkg::CMD_ADD, 0, 100, 200, 1000, 1100, 0, 0, 1, ratt_pkg::ST_OK, 0),
            row(ratt_pkg::CMD_LOOKUP, 150, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_OK, 1050),
            row(ratt_pkg::CMD_LOOKUP, 200, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_MISS, 0),
            row(ratt_pkg::CMD_LOOKUP, 99, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_MISS, 0),
            row(ratt_pkg::CMD_ADD, 0, 150, 160, 5000, 5010, 0, 0, 1, ratt_pkg::ST_POVL, 0),
            row(ratt_pkg::CMD_ADD, 0, 300, 310, 1090, 1100, 0, 0, 1, ratt_pkg::ST_SOVL, 0),
            // touching ranges are not overlaps
            row(ratt_pkg::CMD_ADD, 0, 200, 300, 1100, 1200, 0, 0, 1, ratt_pkg::ST_OK, 0),
            row(ratt_pkg::CMD_UPDATE, 0, 100, 150, 1000, 1050, 1, 2, 1,
                ratt_pkg::ST_NOORIG, 0),
            row(ratt_pkg::CMD_UPDATE, 0, 120, 220, 7000, 7100, 100, 200, 1,
                ratt_pkg::ST_POVL, 0),
            row(ratt_pkg::CMD_UPDATE, 0, 50, 150, 2000, 2100, 100, 200, 1,
                ratt_pkg::ST_OK, 0),
            row(ratt_pkg::CMD_LOOKUP, 50, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_OK, 2000),
            row(ratt_pkg::CMD_UNUSED, 5, 0, 1, 0, 1, 0, 0, 1, ratt_pkg::ST_MISS, 0),
            row(ratt_pkg::CMD_ADD, 0, mx - 16, mx, 0, 16, 0, 0, 1, ratt_pkg::ST_OK, 0),
            row(ratt_pkg::CMD_LOOKUP, mx - 1, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_OK, 15),
            row(ratt_pkg::CMD_LOOKUP, 64'h5555_aaaa_0f0f_f0f0, 0, 0, 0, 0, 0, 0, 0, 0, 0)
        };
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        foreach (dir_rows[i]) send(dir_rows[i]);
        // fill up the table until it reports full
        for (int i = 0; i < ratt_pkg::ENTRIES; i++)
            send(row(ratt_pkg::CMD_ADD, 0, 10000 + i * 8, 10008 + i * 8, 20000 + i * 8,
                     20008 + i * 8, 0, 0, 0, 0, 0));
        set_off(1);
        send(row(ratt_pkg::CMD_LOOKUP, mx, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_OK, mx));
        send(row(ratt_pkg::CMD_ADD, 0, 9, 1, 0, 0, 0, 0, 1, ratt_pkg::ST_OK, 0));
        send(row(ratt_pkg::CMD_UPDATE, 0, 0, 1, 0, 1, 0, 0, 1, ratt_pkg::ST_OK, 0));
        send(row(ratt_pkg::CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 1, ratt_pkg::ST_MISS, 0));
        set_off(0);
        // reset the table contents by churning through updates is not possible,
        // so random phases mostly exercise lookups and updates on a full table
        for (int ph = 0; ph < 7; ph++) begin
            quiet = (ph == 2);
            for (int n = 0; n < 100; n++) begin
                send(rand_req());
                if (ph == 4 && n == 50) drain();
            end
            if (ph == 3) set_off(1);
            if (ph == 4) set_off(0);
        end
        drain();
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* sim.f */
hdl/ratt_pkg.sv
hdl/ratt_ram.sv
hdl/region_address_translation_table.sv
bench/tb_region_address_translation_table.sv
